### sv/lrsc_pkg.sv
// Shared types, constants and trig tables for the lidar segment caster.
`default_nettype none

package lrsc_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int COORD_W      = 24;
   localparam int SEG_W        = 4 * COORD_W;
   localparam int ANGLE_W      = 16;
   localparam int STEP_W       = 12;
   localparam int RANGE_W      = 23;
   localparam int BEAM_W       = 10;
   localparam int SLOT_W       = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 23;
   localparam int TAB_W        = 41;
   localparam int TAB_DEPTH    = 128;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
   localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [TAB_W-1:0]          trig_tab_type [TAB_DEPTH];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_ANGLE_STEP  = 2'd1,
      CSR_MIN_RANGE   = 2'd2,
      CSR_MAX_RANGE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_CAST = 1'b1
   } op_type;

   // cos and sin of r quarter-turn steps (16384 per quarter), Q62 each
   function automatic logic [127:0] trig_q62(input int unsigned r);
      logic [127:0] rr, x, x2, st, ss, ct, cs;
      rr = 128'(r);
      x  = rr * 128'(HALF_PI_Q62 >> 14) + ((rr * 128'(HALF_PI_Q62 & 64'h3FFF)) >> 14);
      x2 = (x * x) >> 62;
      st = x;
      ss = x;
      ct = 128'(ONE_Q62);
      cs = 128'(ONE_Q62);
      for (int k = 1; k < 40; k++) begin
         st = ((st * x2) >> 62) / 128'((2 * k) * (2 * k + 1));
         ct = ((ct * x2) >> 62) / 128'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            ss = ss - st;
            cs = cs - ct;
         end else begin
            ss = ss + st;
            cs = cs + ct;
         end
      end
      return {cs[63:0], ss[63:0]};
   endfunction

   // Q40 table; coarse entries step by 128 units, fine entries by one
   function automatic trig_tab_type build_tab(input logic want_sin, input logic coarse);
      trig_tab_type tab;
      logic [127:0] v;
      logic [63:0]  w;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         v = trig_q62(coarse ? (i * TAB_DEPTH) : i);
         w = want_sin ? v[63:0] : v[127:64];
         tab[i] = TAB_W'((w + 64'h200000) >> 22);
      end
      return tab;
   endfunction

   localparam trig_tab_type COS_COARSE = build_tab(1'b0, 1'b1);
   localparam trig_tab_type SIN_COARSE = build_tab(1'b1, 1'b1);
   localparam trig_tab_type COS_FINE   = build_tab(1'b0, 1'b0);
   localparam trig_tab_type SIN_FINE   = build_tab(1'b1, 1'b0);

endpackage

`default_nettype wire

### sv/lrsc_chan_if.sv
// Channel interfaces: request, response and register write.
`default_nettype none

interface lrsc_req_if import lrsc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [SLOT_W-1:0]   slot;
   coord_type           wall_x1;
   coord_type           wall_y1;
   coord_type           wall_x2;
   coord_type           wall_y2;
   coord_type           origin_x;
   coord_type           origin_y;
   logic signed [ANGLE_W-1:0] heading;
   logic [BEAM_W-1:0]   beam_number;

   modport source (output valid, op, slot, wall_x1, wall_y1, wall_x2, wall_y2,
                   origin_x, origin_y, heading, beam_number, input ready);
   modport sink (input valid, op, slot, wall_x1, wall_y1, wall_x2, wall_y2,
                 origin_x, origin_y, heading, beam_number, output ready);
endinterface

interface lrsc_rsp_if import lrsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] distance;
   logic               hit;
   logic [BEAM_W-1:0]  beam_echo;

   modport source (output valid, distance, hit, beam_echo, input ready);
   modport sink (input valid, distance, hit, beam_echo, output ready);
endinterface

interface lrsc_csr_if import lrsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/lrsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module lrsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/lidar_ray_segment_caster_core.sv
// Lidar beam caster: segment table, sequenced trig, intersection and division.
//
// Use: load wall segments with op 0 requests (slot, two end points); loads give
// no response. An op 1 request casts one beam from origin/heading; its response
// carries the clamped distance, a hit flag and the beam number. The user must
// write registers start_angle, angle_step, min_range, max_range on the csr
// channel (always ready) only while the block is idle; the block itself does
// not enforce this. A cast runs on one shared 33x33 multiplier and one 67-bit
// compare/subtract: it computes the angle, then the direction vector (four
// 41x41 products in parts), then per table entry it skips an empty one, tests
// for a miss or parallel wall, saturates a hit at 2^23 or more, else runs a
// 24-step restoring divide; finally it clamps and registers the response.
// Req ready is low throughout a cast. A new request is taken while the last
// response still waits; a finished cast holds in its final state until the
// response register frees. Reset (synchronous, active high) clears all valid
// marks, the registers to their defaults and the response valid; segment
// coordinates are not cleared.
`default_nettype none

module lidar_ray_segment_caster_core import lrsc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   lrsc_req_if.sink   req_ch,
   lrsc_rsp_if.source rsp_ch,
   lrsc_csr_if.sink   csr_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_ANGLE, S_TRIG, S_SCAN, S_LOAD, S_MUL, S_TEST, S_DIV, S_NEXT, S_DONE
   } state_type;

   localparam int DET_W = 42;
   localparam int TN_W  = 53;
   localparam int REM_W = 67;
   localparam int ACC_W = 84;
   localparam int MUL_W = 33;
   localparam int Q_W   = 24;

   state_type state_ff, state_in;

   // configuration
   logic [ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [STEP_W-1:0]  angle_step_ff, angle_step_in;
   logic [RANGE_W-1:0] min_range_ff, min_range_in;
   logic [RANGE_W-1:0] max_range_ff, max_range_in;

   // cast context
   logic [ANGLE_W-1:0] heading_ff, heading_in;
   logic [ANGLE_W-1:0] ang_ff, ang_in;
   logic [BEAM_W-1:0]  beam_ff, beam_in;
   coord_type          org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [15:0] cos_ff, cos_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [SEG_IDX_W-1:0] idx_ff, idx_in;
   logic signed [COORD_W:0] sx_ff, sx_in, sy_ff, sy_in, rx_ff, rx_in, ry_ff, ry_in;
   logic signed [DET_W-1:0] det_ff, det_in, un_ff, un_in;
   logic signed [TN_W-1:0]  tn_ff, tn_in;
   logic [REM_W-1:0]   rem_ff, rem_in, dsh_ff, dsh_in;
   logic [Q_W-1:0]     quo_ff, quo_in, best_ff, best_in;
   logic               hit_ff, hit_in;
   logic [MAX_SEGMENTS-1:0] seg_valid_ff, seg_valid_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RANGE_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [BEAM_W-1:0]  rsp_beam_ff, rsp_beam_in;

   // segment store
   logic               ram_wr_en, ram_rd_en;
   logic [SEG_W-1:0]   ram_rd_data;
   coord_type          rd_x1, rd_y1, rd_x2, rd_y2;

   // shared multiplier and helpers
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic [TAB_W-1:0]   tab_a, tab_b;
   logic [1:0]         part_sh;
   logic signed [ACC_W-1:0] prod_ext, term, acc_sum, rnd_sum;
   logic signed [15:0] trig_rnd;
   logic               req_fire, load_ok;
   logic signed [DET_W-1:0] det_abs, un_n;
   logic signed [TN_W-1:0]  tn_n;
   logic               reject, ge;
   logic [Q_W-1:0]     t_new, r0, r1, r2, max_ext, min_ext;

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign load_ok       = (32'(req_ch.slot) < MAX_SEGMENTS);
   assign ram_wr_en     = req_fire && (req_ch.op == OP_LOAD) && load_ok;
   assign ram_rd_en     = (state_ff == S_SCAN) && seg_valid_ff[idx_ff];
   assign {rd_x1, rd_y1, rd_x2, rd_y2} = ram_rd_data;

   lrsc_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (SEG_IDX_W'(req_ch.slot)),
      .wr_data ({req_ch.wall_x1, req_ch.wall_y1, req_ch.wall_x2, req_ch.wall_y2}),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.distance  = rsp_dist_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.beam_echo = rsp_beam_ff;

   // trig operands: coarse/fine table product selected by cnt[3:2]
   always_comb begin
      case (cnt_ff[3:2])
         2'd0:    begin tab_a = COS_COARSE[ang_ff[13:7]]; tab_b = COS_FINE[ang_ff[6:0]]; end
         2'd1:    begin tab_a = SIN_COARSE[ang_ff[13:7]]; tab_b = SIN_FINE[ang_ff[6:0]]; end
         2'd2:    begin tab_a = SIN_COARSE[ang_ff[13:7]]; tab_b = COS_FINE[ang_ff[6:0]]; end
         default: begin tab_a = COS_COARSE[ang_ff[13:7]]; tab_b = SIN_FINE[ang_ff[6:0]]; end
      endcase
   end

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_ANGLE: begin
            mul_a = MUL_W'(beam_ff);
            mul_b = MUL_W'(angle_step_ff);
         end
         S_TRIG: begin
            mul_a = cnt_ff[1] ? MUL_W'(tab_a[TAB_W-1:32]) : {1'b0, tab_a[31:0]};
            mul_b = cnt_ff[0] ? MUL_W'(tab_b[TAB_W-1:32]) : {1'b0, tab_b[31:0]};
         end
         S_MUL: begin
            case (cnt_ff[2:0])
               3'd0:    begin mul_a = MUL_W'(dy_ff); mul_b = MUL_W'(sx_ff); end
               3'd1:    begin mul_a = MUL_W'(dx_ff); mul_b = MUL_W'(sy_ff); end
               3'd2:    begin mul_a = MUL_W'(sx_ff); mul_b = MUL_W'(ry_ff); end
               3'd3:    begin mul_a = MUL_W'(sy_ff); mul_b = MUL_W'(rx_ff); end
               3'd4:    begin mul_a = MUL_W'(dx_ff); mul_b = MUL_W'(ry_ff); end
               default: begin mul_a = MUL_W'(dy_ff); mul_b = MUL_W'(rx_ff); end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = ACC_W'(mul_p);
   assign part_sh  = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
   always_comb begin
      case (part_sh)
         2'd2:    term = prod_ext <<< 64;
         2'd1:    term = prod_ext <<< 32;
         default: term = prod_ext;
      endcase
   end
   assign acc_sum  = ((cnt_ff[2:0] == 3'd0) ? ACC_W'(0) : acc_ff)
                   + ((cnt_ff[3:2] == 2'd1) ? -term : term);
   assign rnd_sum  = acc_sum + (ACC_W'(1) <<< 65);
   assign trig_rnd = rnd_sum[81:66];

   // intersection tests after sign normalisation
   assign det_abs = det_ff[DET_W-1] ? -det_ff : det_ff;
   assign tn_n    = det_ff[DET_W-1] ? -tn_ff : tn_ff;
   assign un_n    = det_ff[DET_W-1] ? -un_ff : un_ff;
   assign reject  = (det_ff == '0) || tn_n[TN_W-1] || un_n[DET_W-1] || (un_n > det_abs);
   assign ge      = (rem_ff >= dsh_ff);
   assign t_new   = (cnt_ff == 5'd23) ? {Q_W{1'b1}} : {quo_ff[Q_W-2:0], ge};

   // final clamp: upper first, then lower
   assign max_ext = {1'b0, max_range_ff};
   assign min_ext = {1'b0, min_range_ff};
   assign r0      = hit_ff ? best_ff : max_ext;
   assign r1      = (r0 > max_ext) ? max_ext : r0;
   assign r2      = (r1 < min_ext) ? min_ext : r1;

   always_comb begin
      state_in       = state_ff;
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      min_range_in   = min_range_ff;
      max_range_in   = max_range_ff;
      heading_in     = heading_ff;
      ang_in         = ang_ff;
      beam_in        = beam_ff;
      org_x_in       = org_x_ff;
      org_y_in       = org_y_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      cos_in         = cos_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      idx_in         = idx_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      det_in         = det_ff;
      tn_in          = tn_ff;
      un_in          = un_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      quo_in         = quo_ff;
      best_in        = best_ff;
      hit_in         = hit_ff;
      seg_valid_in   = seg_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_dist_in    = rsp_dist_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_beam_in    = rsp_beam_ff;

      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_START_ANGLE: start_angle_in = csr_ch.data[ANGLE_W-1:0];
            CSR_ANGLE_STEP:  angle_step_in  = csr_ch.data[STEP_W-1:0];
            CSR_MIN_RANGE:   min_range_in   = csr_ch.data[RANGE_W-1:0];
            CSR_MAX_RANGE:   max_range_in   = csr_ch.data[RANGE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.op == OP_LOAD) begin
                  if (load_ok) begin
                     seg_valid_in[SEG_IDX_W'(req_ch.slot)] = 1'b1;
                  end
               end else begin
                  heading_in = req_ch.heading;
                  beam_in    = req_ch.beam_number;
                  org_x_in   = req_ch.origin_x;
                  org_y_in   = req_ch.origin_y;
                  state_in   = S_ANGLE;
               end
            end
         end
         S_ANGLE: begin
            ang_in   = heading_ff + start_angle_ff + mul_p[ANGLE_W-1:0];
            cnt_in   = '0;
            state_in = S_TRIG;
         end
         S_TRIG: begin
            acc_in = acc_sum;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd7) begin
               cos_in = trig_rnd;
            end
            if (cnt_ff == 5'd15) begin
               // rotate the first-quadrant vector into the beam's quadrant
               case (ang_ff[15:14])
                  2'd0:    begin dx_in = cos_ff;    dy_in = trig_rnd;  end
                  2'd1:    begin dx_in = -trig_rnd; dy_in = cos_ff;    end
                  2'd2:    begin dx_in = -cos_ff;   dy_in = -trig_rnd; end
                  default: begin dx_in = trig_rnd;  dy_in = -cos_ff;   end
               endcase
               idx_in   = '0;
               hit_in   = 1'b0;
               best_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            state_in = seg_valid_ff[idx_ff] ? S_LOAD : S_NEXT;
         end
         S_LOAD: begin
            sx_in    = (COORD_W+1)'(rd_x2) - (COORD_W+1)'(rd_x1);
            sy_in    = (COORD_W+1)'(rd_y2) - (COORD_W+1)'(rd_y1);
            rx_in    = (COORD_W+1)'(rd_x1) - (COORD_W+1)'(org_x_ff);
            ry_in    = (COORD_W+1)'(rd_y1) - (COORD_W+1)'(org_y_ff);
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // det = dy*sx - dx*sy, tn = sx*ry - sy*rx, un = dx*ry - dy*rx
            case (cnt_ff[2:0])
               3'd0:    det_in = DET_W'(mul_p);
               3'd1:    det_in = det_ff - DET_W'(mul_p);
               3'd2:    tn_in  = TN_W'(mul_p);
               3'd3:    tn_in  = tn_ff - TN_W'(mul_p);
               3'd4:    un_in  = DET_W'(mul_p);
               default: un_in  = un_ff - DET_W'(mul_p);
            endcase
            cnt_in   = cnt_ff + 5'd1;
            if (cnt_ff == 5'd5) begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (reject) begin
               state_in = S_NEXT;
            end else begin
               rem_in   = REM_W'({tn_n[TN_W-2:0], 14'b0});
               dsh_in   = REM_W'($unsigned(det_abs)) << 23;
               quo_in   = '0;
               cnt_in   = 5'd23;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // first step decides saturation: quotient of 2^23 or more
            if ((cnt_ff == 5'd23 && ge) || cnt_ff == 5'd0) begin
               if (!hit_ff || t_new < best_ff) begin
                  best_in = t_new;
               end
               hit_in   = 1'b1;
               state_in = S_NEXT;
            end else begin
               if (ge) begin
                  rem_in = rem_ff - dsh_ff;
               end
               quo_in = {quo_ff[Q_W-2:0], ge};
               dsh_in = dsh_ff >> 1;
               cnt_in = cnt_ff - 5'd1;
            end
         end
         S_NEXT: begin
            if (idx_ff == SEG_IDX_W'(MAX_SEGMENTS - 1)) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + SEG_IDX_W'(1);
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = r2[RANGE_W-1:0];
               rsp_hit_in   = hit_ff;
               rsp_beam_in  = beam_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         start_angle_ff <= 16'hA000;
         angle_step_ff  <= 12'd60;
         min_range_ff   <= 23'd3277;
         max_range_ff   <= 23'd524288;
         seg_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
         idx_ff         <= '0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         min_range_ff   <= min_range_in;
         max_range_ff   <= max_range_in;
         seg_valid_ff   <= seg_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
         idx_ff         <= idx_in;
         hit_ff         <= hit_in;
      end
      heading_ff  <= heading_in;
      ang_ff      <= ang_in;
      beam_ff     <= beam_in;
      org_x_ff    <= org_x_in;
      org_y_ff    <= org_y_in;
      acc_ff      <= acc_in;
      cos_ff      <= cos_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      det_ff      <= det_in;
      tn_ff       <= tn_in;
      un_ff       <= un_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      best_ff     <= best_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_beam_ff <= rsp_beam_in;
   end

endmodule

`default_nettype wire
